@@ design/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

	// Default operand width and the number of quotient bits resolved per cycle
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int DIV_BITS        = 8;

	localparam int IN_VALUE_W = 32;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PFX_MINUS,
		ST_PFX_ZERO,
		ST_PFX_X,
		ST_POP_RD,
		ST_POP_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_MINUS,
		SEL_ZERO,
		SEL_X,
		SEL_DIGIT
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     div_clr;
		logic     push;
		logic     rd;
		logic     out_load;
		logic     out_last;
		out_sel_t out_sel;
	} i2a_cmd_t;

	typedef struct packed {
		logic neg;
		logic hex;
		logic quot_nz;
		logic depth_last;
		logic out_free;
	} i2a_sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < RADIX_DEC) begin
			c = CH_ZERO + CHAR_W'(d);
		end else begin
			c = CH_A + CHAR_W'(d - RADIX_DEC);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ design/i2a_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2a_ctrl #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output i2a_pkg::i2a_cmd_t    cmd,
	input  wire i2a_pkg::i2a_sts_t sts
);
	import i2a_pkg::*;

	localparam int DW    = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int STEPS = DW / DIV_BITS;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	state_t         state_q, state_d;
	logic [SW-1:0]  step_q;
	logic           step_last;

	assign step_last = (step_q == SW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_last ? '0 : step_q + SW'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_last && !sts.quot_nz) begin
					priority if (sts.neg) state_d = ST_PFX_MINUS;
					else if (sts.hex)     state_d = ST_PFX_ZERO;
					else                  state_d = ST_POP_RD;
				end
			end
			ST_PFX_MINUS: begin
				if (sts.out_free) state_d = ST_POP_RD;
			end
			ST_PFX_ZERO: begin
				if (sts.out_free) state_d = ST_PFX_X;
			end
			ST_PFX_X: begin
				if (sts.out_free) state_d = ST_POP_RD;
			end
			ST_POP_RD: begin
				state_d = ST_POP_OUT;
			end
			ST_POP_OUT: begin
				if (sts.out_free) state_d = sts.depth_last ? ST_IDLE : ST_POP_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.out_sel  = SEL_DIGIT;
		in_stall     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_clr  = (step_q == '0);
				cmd.push     = step_last;
			end
			ST_PFX_MINUS: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_MINUS;
			end
			ST_PFX_ZERO: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_ZERO;
			end
			ST_PFX_X: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_X;
			end
			ST_POP_RD: begin
				cmd.rd = 1'b1;
			end
			ST_POP_OUT: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = sts.depth_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_accept_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DIV))
		else $error("accepted beat did not start a division");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_last |-> (cmd.out_sel == SEL_DIGIT))
		else $error("last marker on a prefix character");

	a_push_on_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (cmd.div_step && step_last))
		else $error("digit pushed before the division pass finished");

endmodule

`default_nettype wire

@@ design/i2a_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2a_dpath #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              func,
	input  wire logic [i2a_pkg::IN_VALUE_W-1:0]    value,
	input  wire logic [i2a_pkg::RADIX_W-1:0]       radix,
	input  wire i2a_pkg::i2a_cmd_t                 cmd,
	output i2a_pkg::i2a_sts_t                      sts,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output logic [i2a_pkg::CHAR_W-1:0]             character,
	output logic                                   last
);
	import i2a_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int DW    = ((W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
	localparam int AW    = $clog2(W);
	localparam int CW    = $clog2(W + 1);

	// Operand preparation
	logic [W-1:0]        v_w, mag;
	logic [RADIX_W-1:0]  radix_c;
	logic                neg_c;

	assign v_w = W'(value);

	always_comb begin
		priority if (radix < RADIX_MIN) radix_c = RADIX_MIN;
		else if (radix > RADIX_MAX)     radix_c = RADIX_MAX;
		else                            radix_c = radix;
	end

	assign neg_c = func && (radix_c == RADIX_DEC) && v_w[W-1];
	assign mag   = neg_c ? W'(~v_w + W'(1)) : v_w;

	// Divider registers
	logic [DW-1:0]       sh_q;
	logic [RADIX_W-1:0]  rem_q, radix_q, rem_nx;
	logic [DIV_BITS-1:0] qb;
	logic                qnz_q, neg_q, hex_q;

	// Resolve DIV_BITS quotient bits per cycle, top bits of the shift register first
	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [RADIX_W:0]   t;
		r  = cmd.div_clr ? '0 : rem_q;
		qb = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, sh_q[DW-1-i]};
			if (t >= {1'b0, radix_q}) begin
				qb[DIV_BITS-1-i] = 1'b1;
				r = RADIX_W'(t - {1'b0, radix_q});
			end else begin
				r = t[RADIX_W-1:0];
			end
		end
		rem_nx = r;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q    <= DW'(mag);
			radix_q <= radix_c;
			neg_q   <= neg_c;
			hex_q   <= (radix_c == RADIX_HEX);
		end else if (cmd.div_step) begin
			sh_q  <= DW'({sh_q, qb});
			rem_q <= rem_nx;
			qnz_q <= (cmd.div_clr ? 1'b0 : qnz_q) | (|qb);
		end
	end

	// Digit stack
	logic [RADIX_W-1:0] mem [W];
	logic [RADIX_W-1:0] rd_q;
	logic [CW-1:0]      cnt_q;
	logic               pop;

	assign pop = cmd.out_load && (cmd.out_sel == SEL_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (pop) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[cnt_q[AW-1:0]] <= rem_nx;
		end
		if (cmd.rd) begin
			rd_q <= mem[AW'(cnt_q - CW'(1))];
		end
	end

	// Output register
	logic                out_valid_q, last_q;
	logic [CHAR_W-1:0]   char_q, char_d;

	always_comb begin
		unique case (cmd.out_sel)
			SEL_MINUS: char_d = CH_MINUS;
			SEL_ZERO:  char_d = CH_ZERO;
			SEL_X:     char_d = CH_X;
			SEL_DIGIT: char_d = digit_char(rd_q);
			default:   char_d = CH_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			char_q <= char_d;
			last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	assign sts.neg        = neg_q;
	assign sts.hex        = hex_q;
	assign sts.quot_nz    = (cmd.div_clr ? 1'b0 : qnz_q) | (|qb);
	assign sts.depth_last = (cnt_q == CW'(1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (cnt_q < CW'(W)))
		else $error("digit stack overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(pop || cmd.rd) |-> (cnt_q != '0))
		else $error("digit stack underflow");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("pending output beat overwritten");

endmodule

`default_nettype wire

@@ design/integer_to_ascii_radix.sv @@
// Sequence: a load, then one divider pass per digit, then the prefix characters one per
//   cycle while the output is free, and a stack read and an output load per digit character.
// A new number is taken only after the last digit character has been loaded out.
// The pace is set by the shared divider resolving 8 quotient bits a cycle.
// Reset (arst_n low) clears the controller, the digit count and output valid; the stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix #(
	parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input beat: one number to convert
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           func,
	input  wire logic [i2a_pkg::IN_VALUE_W-1:0] value,
	input  wire logic [i2a_pkg::RADIX_W-1:0]    radix,
	// output beat: one ASCII character
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [i2a_pkg::CHAR_W-1:0]          character,
	output logic                                last
);
	import i2a_pkg::*;

	// Command and status between the sequencer and the datapath
	i2a_cmd_t cmd;
	i2a_sts_t sts;

	// Sequencer: accept a beat while idle, run the division passes one digit at a
	// time, then emit the prefix and pop the digits most significant first.
	i2a_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: operand capture with sign handling and radix clamp, the
	// iterative multi-bit divider, the digit stack and the output register. The output
	// register lets a new beat be taken while the last character still waits.
	i2a_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.value     (value),
		.radix     (radix),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.character (character),
		.last      (last)
	);

endmodule

`default_nettype wire
